// File: hdl/lnc_pkg.sv
// Shared types, register addresses and constants of the noise channel.
// Used by the top level and the testbench; depends on nothing.

package lnc_pkg;

    localparam int PERIOD_W = 21;
    localparam int LFSR_W   = 15;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_LENGTH   = 3'd1,
        OP_ENVELOPE = 3'd2,
        OP_WRITE    = 3'd3,
        OP_READ     = 3'd4
    } opcode_t;

    localparam logic [15:0] ADDR_NR41 = 16'hff20;
    localparam logic [15:0] ADDR_NR42 = 16'hff21;
    localparam logic [15:0] ADDR_NR43 = 16'hff22;
    localparam logic [15:0] ADDR_NR44 = 16'hff23;

    localparam logic [5:0] LEN_MASK      = 6'h3f;
    localparam int         TRIGGER_BIT   = 7;
    localparam logic [3:0] NO_STEP_SHIFT = 4'd14;
    localparam logic [7:0] READ_OPEN     = 8'hff;
    localparam int         SHORT_TAP     = 6;

    localparam logic [5:0] DIVISOR_TABLE [8] = '{
        6'd4, 6'd8, 6'd16, 6'd24, 6'd32, 6'd40, 6'd48, 6'd56
    };

    // Divisor shifted by the clock shift, cut to the timer width.
    function automatic logic [PERIOD_W-1:0] reload_value(
        input logic [2:0] divisor_code,
        input logic [3:0] clock_shift
    );
        logic [PERIOD_W-1:0] base;
        base = PERIOD_W'(DIVISOR_TABLE[divisor_code]);
        return base << clock_shift;
    endfunction

endpackage

// File: hdl/lnc_op_if.sv
// Operation channel of the noise channel: valid/ready plus one operation word.
// Uses no package items.

interface lnc_op_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_value;

    modport source (output valid, opcode, bus_address, write_value, input ready);
    modport sink   (input valid, opcode, bus_address, write_value, output ready);
endinterface

// File: hdl/lnc_res_if.sv
// Result channel of the noise channel: valid/ready plus one result word.
// Uses no package items.

interface lnc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic [3:0] sample_level;
    logic       channel_active;

    modport source (output valid, read_value, sample_level, channel_active, input ready);
    modport sink   (input valid, read_value, sample_level, channel_active, output ready);
endinterface

// File: hdl/lfsr_noise_channel.sv
// Noise channel of a handheld console sound unit: period timer, 15/7-bit LFSR,
// envelope, length counter and register file. Depends on lnc_pkg, lnc_op_if, lnc_res_if.
//
// Usage:
//   op  (sink)  : one operation word per handshake: tick, length clock,
//                 envelope clock, bus write or bus read (opcodes 5..7 do nothing).
//   res (source): exactly one result word per operation, in order: read data
//                 (zero unless a bus read), held sample level, channel enable.
//   Throughput: one operation per cycle while res.ready stays high. An accepted
//   word sits in the input register, where the channel state and the result
//   register are updated together once the result register is free; the
//   result then stays valid in the result register until it is taken.
//   Stall: the result register holds while res.ready is low; the input
//   register still takes one more word, then op.ready drops until the
//   result is taken. Nothing is lost or repeated.
//   Reset: rst_n low clears all channel state to zero (channel off, LFSR
//   and timers zero) and empties both registers. No init sequence needed.

module lfsr_noise_channel (
    input logic       clk,
    input logic       rst_n,
    lnc_op_if.sink    op,
    lnc_res_if.source res
);

    localparam int PW = lnc_pkg::PERIOD_W;
    localparam int LW = lnc_pkg::LFSR_W;

    // input register
    logic        in_valid_reg;
    logic [2:0]  in_opcode_reg;
    logic [15:0] in_address_reg;
    logic [7:0]  in_data_reg;

    // result register
    logic        res_valid_reg;
    logic [7:0]  res_read_reg;
    logic [3:0]  res_sample_reg;
    logic        res_active_reg;

    // channel state
    logic          channel_on_reg, channel_on_next;
    logic [3:0]    initial_volume_reg, initial_volume_next;
    logic          envelope_up_reg, envelope_up_next;
    logic [2:0]    envelope_step_reg, envelope_step_next;
    logic [3:0]    clock_shift_reg, clock_shift_next;
    logic          short_mode_reg, short_mode_next;
    logic [2:0]    divisor_code_reg, divisor_code_next;
    logic          length_stop_reg, length_stop_next;
    logic [5:0]    length_count_reg, length_count_next;
    logic [2:0]    envelope_timer_reg, envelope_timer_next;
    logic [3:0]    current_volume_reg, current_volume_next;
    logic [PW-1:0] period_timer_reg, period_timer_next;
    logic [LW-1:0] shift_register_reg, shift_register_next;
    logic [3:0]    held_sample_reg, held_sample_next;

    logic          res_free;
    logic          process;
    logic [7:0]    read_data;
    logic [PW-1:0] period_dec;
    logic [LW-1:0] lfsr_step;
    logic          feedback;
    logic [5:0]    length_inc;
    logic [2:0]    envelope_dec;
    logic          dac_on_write;
    logic          dac_on_now;
    logic          trigger_fire;

    assign res_free = !res_valid_reg || res.ready;
    assign process  = in_valid_reg && res_free;
    assign op.ready = !in_valid_reg || res_free;

    assign res.valid          = res_valid_reg;
    assign res.read_value     = res_read_reg;
    assign res.sample_level   = res_sample_reg;
    assign res.channel_active = res_active_reg;

    assign period_dec   = period_timer_reg - PW'(1);
    assign feedback     = shift_register_reg[0] ^ shift_register_reg[1];
    assign length_inc   = length_count_reg + 6'd1;
    assign envelope_dec = envelope_timer_reg - 3'd1;

    // Shift right; feed back at the top bit, or at bit 6 only in short mode.
    always_comb
    begin
        lfsr_step = {1'b0, shift_register_reg[LW-1:1]};
        if (short_mode_reg)
        begin
            lfsr_step[lnc_pkg::SHORT_TAP] = lfsr_step[lnc_pkg::SHORT_TAP] ^ feedback;
        end
        else
        begin
            lfsr_step[LW-1] = feedback;
        end
    end

    // DAC state as written by a volume register write, and as currently held
    assign dac_on_write = (in_data_reg[7:4] != 4'd0) || in_data_reg[3];
    assign dac_on_now   = (initial_volume_reg != 4'd0) || envelope_up_reg;
    assign trigger_fire = process && (in_opcode_reg == lnc_pkg::OP_WRITE)
                          && (in_address_reg == lnc_pkg::ADDR_NR44)
                          && in_data_reg[lnc_pkg::TRIGGER_BIT];

    always_comb
    begin
        channel_on_next     = channel_on_reg;
        initial_volume_next = initial_volume_reg;
        envelope_up_next    = envelope_up_reg;
        envelope_step_next  = envelope_step_reg;
        clock_shift_next    = clock_shift_reg;
        short_mode_next     = short_mode_reg;
        divisor_code_next   = divisor_code_reg;
        length_stop_next    = length_stop_reg;
        length_count_next   = length_count_reg;
        envelope_timer_next = envelope_timer_reg;
        current_volume_next = current_volume_reg;
        period_timer_next   = period_timer_reg;
        shift_register_next = shift_register_reg;
        held_sample_next    = held_sample_reg;
        read_data           = 8'd0;

        if (process)
        begin
            case (in_opcode_reg)
                lnc_pkg::OP_TICK:
                begin
                    if (period_timer_reg != PW'(0))
                    begin
                        period_timer_next = period_dec;
                        if (period_dec == PW'(0))
                        begin
                            period_timer_next = lnc_pkg::reload_value(divisor_code_reg,
                                                                      clock_shift_reg);
                            if (clock_shift_reg < lnc_pkg::NO_STEP_SHIFT)
                            begin
                                shift_register_next = lfsr_step;
                            end
                        end
                    end
                    held_sample_next = (channel_on_reg && !shift_register_next[0])
                                       ? current_volume_reg : 4'd0;
                end
                lnc_pkg::OP_LENGTH:
                begin
                    if (length_stop_reg)
                    begin
                        length_count_next = length_inc;
                        if (length_inc == 6'd0)
                        begin
                            channel_on_next = 1'b0;
                        end
                    end
                end
                lnc_pkg::OP_ENVELOPE:
                begin
                    if (channel_on_reg && envelope_step_reg != 3'd0)
                    begin
                        envelope_timer_next = envelope_dec;
                        if (envelope_dec == 3'd0)
                        begin
                            envelope_timer_next = envelope_step_reg;
                            if (!envelope_up_reg && current_volume_reg != 4'd0)
                            begin
                                current_volume_next = current_volume_reg - 4'd1;
                            end
                            if (envelope_up_reg && current_volume_reg != 4'hf)
                            begin
                                current_volume_next = current_volume_reg + 4'd1;
                            end
                        end
                    end
                end
                lnc_pkg::OP_WRITE:
                begin
                    case (in_address_reg)
                        lnc_pkg::ADDR_NR41:
                        begin
                            length_count_next = in_data_reg[5:0] & lnc_pkg::LEN_MASK;
                        end
                        lnc_pkg::ADDR_NR42:
                        begin
                            initial_volume_next = in_data_reg[7:4];
                            envelope_up_next    = in_data_reg[3];
                            envelope_step_next  = in_data_reg[2:0];
                            if (!dac_on_write)
                            begin
                                channel_on_next = 1'b0;
                            end
                        end
                        lnc_pkg::ADDR_NR43:
                        begin
                            clock_shift_next  = in_data_reg[7:4];
                            short_mode_next   = in_data_reg[3];
                            divisor_code_next = in_data_reg[2:0];
                            period_timer_next = lnc_pkg::reload_value(in_data_reg[2:0],
                                                                      in_data_reg[7:4]);
                        end
                        lnc_pkg::ADDR_NR44:
                        begin
                            length_stop_next = in_data_reg[6];
                            if (in_data_reg[lnc_pkg::TRIGGER_BIT])
                            begin
                                channel_on_next     = dac_on_now;
                                shift_register_next = {LW{1'b1}};
                                envelope_timer_next = envelope_step_reg;
                                current_volume_next = initial_volume_reg;
                            end
                        end
                        default:
                        begin
                            // undecoded address: drop the write
                        end
                    endcase
                end
                lnc_pkg::OP_READ:
                begin
                    case (in_address_reg)
                        lnc_pkg::ADDR_NR42:
                            read_data = {initial_volume_reg, envelope_up_reg, envelope_step_reg};
                        lnc_pkg::ADDR_NR43:
                            read_data = {clock_shift_reg, short_mode_reg, divisor_code_reg};
                        lnc_pkg::ADDR_NR44:
                            read_data = {1'b1, length_stop_reg, lnc_pkg::LEN_MASK};
                        default:
                            read_data = lnc_pkg::READ_OPEN;
                    endcase
                end
                default:
                begin
                    // unused opcode: no state change
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            res_valid_reg      <= 1'b0;
            channel_on_reg     <= 1'b0;
            initial_volume_reg <= 4'd0;
            envelope_up_reg    <= 1'b0;
            envelope_step_reg  <= 3'd0;
            clock_shift_reg    <= 4'd0;
            short_mode_reg     <= 1'b0;
            divisor_code_reg   <= 3'd0;
            length_stop_reg    <= 1'b0;
            length_count_reg   <= 6'd0;
            envelope_timer_reg <= 3'd0;
            current_volume_reg <= 4'd0;
            period_timer_reg   <= '0;
            shift_register_reg <= '0;
            held_sample_reg    <= 4'd0;
        end
        else
        begin
            if (op.ready)
            begin
                in_valid_reg <= op.valid;
            end
            if (res_free)
            begin
                res_valid_reg <= in_valid_reg;
            end
            channel_on_reg     <= channel_on_next;
            initial_volume_reg <= initial_volume_next;
            envelope_up_reg    <= envelope_up_next;
            envelope_step_reg  <= envelope_step_next;
            clock_shift_reg    <= clock_shift_next;
            short_mode_reg     <= short_mode_next;
            divisor_code_reg   <= divisor_code_next;
            length_stop_reg    <= length_stop_next;
            length_count_reg   <= length_count_next;
            envelope_timer_reg <= envelope_timer_next;
            current_volume_reg <= current_volume_next;
            period_timer_reg   <= period_timer_next;
            shift_register_reg <= shift_register_next;
            held_sample_reg    <= held_sample_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (op.ready && op.valid)
        begin
            in_opcode_reg  <= op.opcode;
            in_address_reg <= op.bus_address;
            in_data_reg    <= op.write_value;
        end
        if (process)
        begin
            res_read_reg   <= read_data;
            res_sample_reg <= held_sample_next;
            res_active_reg <= channel_on_next;
        end
    end

`ifndef SYNTH
    // channel never runs with its DAC off
    a_dac_gates_channel: assert property (@(posedge clk) disable iff (!rst_n)
        channel_on_reg |-> (initial_volume_reg != 4'd0 || envelope_up_reg))
        else $error("channel on while DAC is off");

    // trigger loads the volume and reseeds the LFSR
    a_trigger_reload: assert property (@(posedge clk) disable iff (!rst_n)
        trigger_fire |=> (current_volume_reg == $past(initial_volume_reg))
                         && (shift_register_reg == {LW{1'b1}}))
        else $error("trigger did not reload volume and LFSR");

    // a processed word always lands in the result register
    a_word_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> res_valid_reg)
        else $error("processed word lost before result register");

    // a stalled result blocks further processing
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |-> !process)
        else $error("word processed while result register is full");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lfsr_noise_channel: directed register/timer cases, then random
// programming sessions of the noise channel under several idling phases.
// Depends on lnc_pkg, lnc_op_if, lnc_res_if and the lfsr_noise_channel RTL.

module tb;

    localparam logic [15:0] ADDR_NR40      = 16'hff1f;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
    localparam int          RANDOM_OPS     = 1750;
    localparam int          PHASE_OPS      = 200;
    localparam int          QUIET_LIMIT    = 4000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          REPORT_MAX     = 10;

    typedef struct packed {
        logic [2:0]  code;
        logic [15:0] addr;
        logic [7:0]  data;
    } noise_op_t;

    typedef struct packed {
        logic [7:0] rd;
        logic [3:0] level;
        logic       active;
    } noise_word_t;

    logic clk;
    logic rst_n;

    lnc_op_if  op_ch ();
    lnc_res_if res_ch ();

    lfsr_noise_channel dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .res   (res_ch)
    );

    noise_op_t   op_backlog[$];
    noise_word_t expected_words[$];
    int          ops_total;
    int          ops_accepted;
    int          mismatches;
    int          quiet_cycles;

    // Predicted channel state
    logic                         ch_on;
    logic [3:0]                   vol_init;
    logic                         env_dir_up;
    logic [2:0]                   env_period;
    logic [3:0]                   shift_amt;
    logic                         narrow_mode;
    logic [2:0]                   div_sel;
    logic                         len_en;
    logic [5:0]                   len_cnt;
    logic [2:0]                   env_cnt;
    logic [3:0]                   vol_now;
    logic [lnc_pkg::PERIOD_W-1:0] period_cnt;
    logic [lnc_pkg::LFSR_W-1:0]   lfsr;
    logic [3:0]                   sample_hold;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [lnc_pkg::PERIOD_W-1:0] period_reload(input logic [2:0] code,
                                                                 input logic [3:0] sh);
        logic [lnc_pkg::PERIOD_W-1:0] base;
        base = (code == 3'd0) ? lnc_pkg::PERIOD_W'(4) : lnc_pkg::PERIOD_W'({code, 3'b000});
        return base << sh;
    endfunction

    function automatic int idle_share(input int phase, input bit receiver);
        case (phase)
            1: return receiver ? 0 : 62;
            2: return receiver ? 62 : 0;
            3: return 8;
            default: return 0;
        endcase
    endfunction

    // Advance the predicted channel by one operation and queue the word it yields.
    task automatic apply_noise_op(input noise_op_t w);
        noise_word_t                outw;
        logic                       fb;
        logic [lnc_pkg::LFSR_W-1:0] nxt;
        logic                       dac;
        outw = '0;
        case (w.code)
            lnc_pkg::OP_TICK:
            begin
                if (period_cnt != '0)
                begin
                    period_cnt = period_cnt - 1'b1;
                    if (period_cnt == '0)
                    begin
                        period_cnt = period_reload(div_sel, shift_amt);
                        if (shift_amt < lnc_pkg::NO_STEP_SHIFT)
                        begin
                            fb  = lfsr[0] ^ lfsr[1];
                            nxt = lfsr >> 1;
                            if (narrow_mode)
                                nxt[lnc_pkg::SHORT_TAP] = nxt[lnc_pkg::SHORT_TAP] ^ fb;
                            else
                                nxt[lnc_pkg::LFSR_W-1] = nxt[lnc_pkg::LFSR_W-1] ^ fb;
                            lfsr = nxt;
                        end
                    end
                end
                sample_hold = (ch_on && !lfsr[0]) ? vol_now : 4'd0;
            end
            lnc_pkg::OP_LENGTH:
            begin
                if (len_en)
                begin
                    len_cnt = len_cnt + 1'b1;
                    if (len_cnt == '0)
                        ch_on = 1'b0;
                end
            end
            lnc_pkg::OP_ENVELOPE:
            begin
                if (ch_on && env_period != '0)
                begin
                    env_cnt = env_cnt - 1'b1;
                    if (env_cnt == '0)
                    begin
                        env_cnt = env_period;
                        if (!env_dir_up && vol_now != 4'd0)
                            vol_now = vol_now - 1'b1;
                        if (env_dir_up && vol_now != 4'd15)
                            vol_now = vol_now + 1'b1;
                    end
                end
            end
            lnc_pkg::OP_WRITE:
            begin
                if (w.addr == lnc_pkg::ADDR_NR41)
                    len_cnt = w.data[5:0];
                else if (w.addr == lnc_pkg::ADDR_NR42)
                begin
                    vol_init   = w.data[7:4];
                    env_dir_up = w.data[3];
                    env_period = w.data[2:0];
                    if (vol_init == '0 && !env_dir_up)
                        ch_on = 1'b0;
                end
                else if (w.addr == lnc_pkg::ADDR_NR43)
                begin
                    shift_amt   = w.data[7:4];
                    narrow_mode = w.data[3];
                    div_sel     = w.data[2:0];
                    period_cnt  = period_reload(div_sel, shift_amt);
                end
                else if (w.addr == lnc_pkg::ADDR_NR44)
                begin
                    len_en = w.data[6];
                    if (w.data[lnc_pkg::TRIGGER_BIT])
                    begin
                        dac     = (vol_init != '0) || env_dir_up;
                        ch_on   = dac;
                        lfsr    = '1;
                        env_cnt = env_period;
                        vol_now = vol_init;
                    end
                end
            end
            lnc_pkg::OP_READ:
            begin
                if (w.addr == lnc_pkg::ADDR_NR42)
                    outw.rd = {vol_init, env_dir_up, env_period};
                else if (w.addr == lnc_pkg::ADDR_NR43)
                    outw.rd = {shift_amt, narrow_mode, div_sel};
                else if (w.addr == lnc_pkg::ADDR_NR44)
                    outw.rd = {1'b1, len_en, lnc_pkg::LEN_MASK};
                else
                    outw.rd = lnc_pkg::READ_OPEN;
            end
            default: ;
        endcase
        outw.level  = sample_hold;
        outw.active = ch_on;
        expected_words.push_back(outw);
    endtask

    task automatic queue_op(input logic [2:0] code, input logic [15:0] addr,
                            input logic [7:0] data);
        noise_op_t w;
        w.code = code;
        w.addr = addr;
        w.data = data;
        op_backlog.push_back(w);
    endtask

    function automatic logic [15:0] pick_reg_addr();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return ADDR_NR40;
            1: return lnc_pkg::ADDR_NR41;
            2: return lnc_pkg::ADDR_NR42;
            3: return lnc_pkg::ADDR_NR43;
            4: return lnc_pkg::ADDR_NR44;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One programming of the channel followed by a burst of mixed operations.
    task automatic queue_session();
        logic [3:0] sh;
        logic [7:0] len_byte;
        int         burst;
        int         r;
        sh = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 2));
        len_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(56, 63))
                                              : 8'($urandom_range(0, 255));
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR42, 8'($urandom_range(0, 255)));
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR43, {sh, 4'($urandom_range(0, 15))});
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR41, len_byte);
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR44, {($urandom_range(0, 7) != 0),
                                                          7'($urandom_range(0, 127))});
        burst = $urandom_range(15, 60);
        for (int i = 0; i < burst; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                queue_op(lnc_pkg::OP_TICK, 16'($urandom), 8'($urandom));
            else if (r < 60)
                queue_op(lnc_pkg::OP_LENGTH, 16'($urandom), 8'($urandom));
            else if (r < 78)
                queue_op(lnc_pkg::OP_ENVELOPE, 16'($urandom), 8'($urandom));
            else if (r < 88)
                queue_op(lnc_pkg::OP_READ, pick_reg_addr(), 8'($urandom));
            else if (r < 96)
                queue_op(lnc_pkg::OP_WRITE, pick_reg_addr(), 8'($urandom));
            else if (r < 98)
                queue_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                         16'($urandom), 8'($urandom));
            else
                queue_op(lnc_pkg::OP_WRITE, 16'($urandom), 8'($urandom));
        end
    endtask

    // Driver: hold the word until taken, then load the next or idle.
    always @(posedge clk)
    begin
        noise_op_t w;
        if (rst_n)
        begin
            if (op_ch.valid && op_ch.ready)
            begin
                w.code = op_ch.opcode;
                w.addr = op_ch.bus_address;
                w.data = op_ch.write_value;
                apply_noise_op(w);
                ops_accepted <= ops_accepted + 1;
            end
            if (!op_ch.valid || op_ch.ready)
            begin
                if (op_backlog.size() > 0 &&
                    $urandom_range(0, 99) >= idle_share((ops_accepted / PHASE_OPS) % 4, 1'b0))
                begin
                    w = op_backlog.pop_front();
                    op_ch.valid       <= 1'b1;
                    op_ch.opcode      <= w.code;
                    op_ch.bus_address <= w.addr;
                    op_ch.write_value <= w.data;
                end
                else
                    op_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each taken result word against the oldest prediction.
    always @(posedge clk)
    begin
        noise_word_t exp_w;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected result word: rd=%h level=%h active=%b",
                                 res_ch.read_value, res_ch.sample_level,
                                 res_ch.channel_active);
                    mismatches++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (res_ch.read_value !== exp_w.rd || res_ch.sample_level !== exp_w.level ||
                        res_ch.channel_active !== exp_w.active)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display({"mismatch: expected rd=%h level=%h active=%b, ",
                                      "got rd=%h level=%h active=%b"},
                                     exp_w.rd, exp_w.level, exp_w.active, res_ch.read_value,
                                     res_ch.sample_level, res_ch.channel_active);
                        mismatches++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >=
                             idle_share((ops_accepted / PHASE_OPS) % 4, 1'b1));
        end
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        op_ch.valid          = 1'b0;
        op_ch.opcode         = lnc_pkg::OP_TICK;
        op_ch.bus_address    = '0;
        op_ch.write_value    = '0;
        res_ch.ready         = 1'b0;
        ops_accepted         = 0;
        mismatches           = 0;
        quiet_cycles         = 0;
        {ch_on, vol_init, env_dir_up, env_period, shift_amt, narrow_mode, div_sel} = '0;
        {len_en, len_cnt, env_cnt, vol_now, period_cnt, lfsr, sample_hold} = '0;

        // Directed: open reads, idle timer, dead channel, spare opcodes
        queue_op(lnc_pkg::OP_READ, ADDR_NR40, 8'h00);
        queue_op(lnc_pkg::OP_READ, 16'h0000, 8'hff);
        queue_op(lnc_pkg::OP_READ, 16'hffff, 8'h00);
        queue_op(lnc_pkg::OP_TICK, 16'hffff, 8'hff);
        queue_op(lnc_pkg::OP_ENVELOPE, 16'h0000, 8'h00);
        queue_op(lnc_pkg::OP_LENGTH, 16'h0000, 8'h00);
        queue_op(OP_SPARE_FIRST, lnc_pkg::ADDR_NR42, 8'h00);
        queue_op(OP_SPARE_LAST, 16'hffff, 8'hff);
        // Trigger with envelope period 0, then set a period: timer wraps from zero
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR42, 8'hf0);
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR44, 8'hc0);
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR42, 8'hf1);
        queue_op(lnc_pkg::OP_ENVELOPE, 16'h0000, 8'h00);
        // Shortest period in short mode: LFSR steps on the fourth tick
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR43, 8'h08);
        for (int i = 0; i < 4; i++)
            queue_op(lnc_pkg::OP_TICK, 16'h0000, 8'h00);
        queue_op(lnc_pkg::OP_READ, lnc_pkg::ADDR_NR43, 8'h00);
        // Largest shift and divisor: timer reloads, then writes to undecoded addresses
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR43, 8'hff);
        queue_op(lnc_pkg::OP_WRITE, ADDR_NR40, 8'hff);
        queue_op(lnc_pkg::OP_WRITE, 16'h0000, 8'hff);
        // Length counter at 63 wraps on the next length clock and shuts the channel
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR41, 8'hff);
        queue_op(lnc_pkg::OP_LENGTH, 16'h0000, 8'h00);
        queue_op(lnc_pkg::OP_READ, lnc_pkg::ADDR_NR44, 8'h00);
        // DAC off: write drops the channel, trigger keeps it off
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR42, 8'h00);
        queue_op(lnc_pkg::OP_WRITE, lnc_pkg::ADDR_NR44, 8'h80);
        queue_op(lnc_pkg::OP_READ, lnc_pkg::ADDR_NR42, 8'h00);

        while (op_backlog.size() < RANDOM_OPS)
            queue_session();
        ops_total = op_backlog.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted < ops_total)
            @(posedge clk);
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/lnc_pkg.sv
hdl/lnc_op_if.sv
hdl/lnc_res_if.sv
hdl/lfsr_noise_channel.sv
verif/tb.sv
